>>> src/rgbhsi_pkg.sv
package rgbhsi_pkg;

  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned XY_W = 36;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [16:0] SQRT3_Q16 = 17'd113512;
  localparam int unsigned SUM_W = 10;
  localparam int unsigned QUO_W = 8;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] hue_code;
    logic [7:0] saturation_code;
    logic [7:0] intensity_code;
  } pixel_out_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;
      5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;
      5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;
      5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic signed [XY_W-1:0] shr_tz(input logic signed [XY_W-1:0] v,
                                                   input logic [4:0] s);
    logic [XY_W-1:0] m;
    m = v[XY_W-1] ? (~v + 1'b1) : v;
    m = m >> s;
    return v[XY_W-1] ? $signed(~m + 1'b1) : $signed(m);
  endfunction

endpackage

>>> src/rgb_to_hsi_pixel.sv
// Channel | Direction | Handshake           | Beat
// pixel   | in        | start, busy         | pixel_in (red, green, blue)
// result  | out       | done (strobe)       | pixel_out (hue, saturation, intensity)
// A pixel may be started in every cycle; busy is never raised.
// Each result appears on pixel_out with done high for one cycle.
// The latency is set by the CORDIC chain, one iteration to a stage.
// Synchronous reset clears the valid bits only; the receiver cannot stall.
module rgb_to_hsi_pixel
  import rgbhsi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  pixel_in_t  pixel_in,
  output logic       done,
  output pixel_out_t pixel_out
);

  localparam int unsigned DEPTH = CORDIC_STEPS + 2;
  localparam int unsigned DIV3_MUL = 683;
  localparam int unsigned DIV3_SHIFT = 11;

  logic [DEPTH-1:0] vld;
  logic accept;
  assign busy = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-2:0], accept};
    end
  end

  // Stage 1: sum, minimum, vector components.
  logic [SUM_W-1:0] s1_sum, s1_tmin;
  logic [7:0] s1_mn;
  logic signed [10:0] s1_xr;
  logic signed [8:0] s1_yr;
  logic [7:0] mn_rg, mn_all;
  assign mn_rg = (pixel_in.green < pixel_in.red) ? pixel_in.green : pixel_in.red;
  assign mn_all = (pixel_in.blue < mn_rg) ? pixel_in.blue : mn_rg;

  always_ff @(posedge clk) begin
    s1_sum <= SUM_W'(pixel_in.red) + SUM_W'(pixel_in.green) + SUM_W'(pixel_in.blue);
    s1_mn <= mn_all;
    s1_tmin <= SUM_W'(mn_all) * SUM_W'(3);
    s1_xr <= $signed({3'b0, pixel_in.red} <<< 1) - $signed({3'b0, pixel_in.green})
             - $signed({3'b0, pixel_in.blue});
    s1_yr <= $signed({1'b0, pixel_in.green}) - $signed({1'b0, pixel_in.blue});
  end

  // Stage 2: scaled vector, pre-rotation, flags.
  logic signed [XY_W-1:0] c_x [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] c_y [CORDIC_STEPS+1];
  logic [31:0] c_z [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] xs, ys;
  logic s2_chroma, s2_mnz, s2_ysz, s2_xpos;
  logic [SUM_W-1:0] s2_sum, s2_diff;
  assign xs = XY_W'(s1_xr) <<< 16;
  assign ys = XY_W'(s1_yr) * $signed({1'b0, SQRT3_Q16});

  always_ff @(posedge clk) begin
    s2_chroma <= (s1_sum != '0) && (s1_sum != s1_tmin);
    s2_mnz <= (s1_mn == 8'd0);
    s2_ysz <= (s1_yr == '0);
    s2_xpos <= (s1_xr > 0);
    s2_sum <= s1_sum;
    s2_diff <= s1_sum - s1_tmin;
    if (s1_xr < 0) begin
      c_x[0] <= -xs;
      c_y[0] <= -ys;
      c_z[0] <= HALF_TURN;
    end else begin
      c_x[0] <= xs;
      c_y[0] <= ys;
      c_z[0] <= '0;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    rgbhsi_cordic_stage #(.STEP(g)) u_stage (
      .clk(clk), .x_in(c_x[g]), .y_in(c_y[g]), .z_in(c_z[g]),
      .x_out(c_x[g+1]), .y_out(c_y[g+1]), .z_out(c_z[g+1])
    );
  end

  // Side pipeline alongside the CORDIC: saturation by restoring division,
  // one quotient bit to a stage.
  logic [SUM_W+8-1:0] num;
  logic [SUM_W-1:0] dv_rem [QUO_W+1];
  logic [QUO_W-1:0] dv_num [QUO_W+1];
  logic [SUM_W-1:0] dv_dsr [QUO_W+1];
  assign num = (SUM_W+8)'(s2_diff) * (SUM_W+8)'(255);

  always_ff @(posedge clk) begin
    dv_rem[0] <= num[SUM_W+7:8];
    dv_num[0] <= num[7:0];
    dv_dsr[0] <= s2_sum;
    for (int k = 1; k <= QUO_W; k++) begin
      if ({dv_rem[k-1], dv_num[k-1][QUO_W-1]} >= {1'b0, dv_dsr[k-1]}) begin
        dv_rem[k] <= SUM_W'({dv_rem[k-1], dv_num[k-1][QUO_W-1]} - {1'b0, dv_dsr[k-1]});
        dv_num[k] <= {dv_num[k-1][QUO_W-2:0], 1'b1};
      end else begin
        dv_rem[k] <= SUM_W'({dv_rem[k-1], dv_num[k-1][QUO_W-1]});
        dv_num[k] <= {dv_num[k-1][QUO_W-2:0], 1'b0};
      end
      dv_dsr[k] <= dv_dsr[k-1];
    end
  end

  logic [7:0] sat_d [QUO_W+1:CORDIC_STEPS];
  logic [7:0] int_d [CORDIC_STEPS+1];
  logic chr_d [CORDIC_STEPS+1];
  logic mnz_d [CORDIC_STEPS+1];
  logic ysz_d [CORDIC_STEPS+1];
  logic xpos_d [CORDIC_STEPS+1];
  logic [7:0] int_q;

  always_ff @(posedge clk) begin
    int_q <= 8'((20'(s1_sum) * 20'(DIV3_MUL)) >> DIV3_SHIFT);
    int_d[0] <= int_q;
    chr_d[0] <= s2_chroma;
    mnz_d[0] <= s2_mnz;
    ysz_d[0] <= s2_ysz;
    xpos_d[0] <= s2_xpos;
    for (int i = 1; i <= CORDIC_STEPS; i++) begin
      int_d[i] <= int_d[i-1];
      chr_d[i] <= chr_d[i-1];
      mnz_d[i] <= mnz_d[i-1];
      ysz_d[i] <= ysz_d[i-1];
      xpos_d[i] <= xpos_d[i-1];
    end
    sat_d[QUO_W+1] <= !chr_d[QUO_W] ? 8'd0 : (mnz_d[QUO_W] ? 8'd255 : dv_num[QUO_W]);
    for (int i = QUO_W + 2; i <= CORDIC_STEPS; i++) begin
      sat_d[i] <= sat_d[i-1];
    end
  end

  // Final stage: choose the angle, scale it to a hue code and register the whole result beat.
  logic [31:0] ang;
  logic [39:0] prod;
  assign ang = ysz_d[CORDIC_STEPS-1] ? (xpos_d[CORDIC_STEPS-1] ? 32'h0 : HALF_TURN)
                                    : c_z[CORDIC_STEPS];
  assign prod = 40'(ang) * 40'(255);

  always_ff @(posedge clk) begin
    done <= vld[DEPTH-1] && !rst;
    pixel_out.hue_code <= chr_d[CORDIC_STEPS-1] ? prod[39:32] : 8'd0;
    pixel_out.saturation_code <= sat_d[CORDIC_STEPS-1];
    pixel_out.intensity_code <= int_d[CORDIC_STEPS-1];
  end

  assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  assert property (@(posedge clk) disable iff (rst)
                   done |-> (pixel_out.hue_code != 8'd255))
    else $error("hue code out of range");
  assert property (@(posedge clk) disable iff (rst)
                   done |-> !$isunknown(pixel_out))
    else $error("unknown bits on a result beat");

endmodule

>>> src/rgbhsi_cordic_stage.sv
module rgbhsi_cordic_stage
  import rgbhsi_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic                   clk,
  input  logic signed [XY_W-1:0] x_in,
  input  logic signed [XY_W-1:0] y_in,
  input  logic [31:0]            z_in,
  output logic signed [XY_W-1:0] x_out,
  output logic signed [XY_W-1:0] y_out,
  output logic [31:0]            z_out
);

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;

  assign dx = shr_tz(y_in, 5'(STEP));
  assign dy = shr_tz(x_in, 5'(STEP));

  always_ff @(posedge clk) begin
    if (!y_in[XY_W-1]) begin
      x_out <= x_in + dx;
      y_out <= y_in - dy;
      z_out <= z_in + atan_turn(5'(STEP));
    end else begin
      x_out <= x_in - dx;
      y_out <= y_in + dy;
      z_out <= z_in - atan_turn(5'(STEP));
    end
  end

endmodule

>>> dv/rgb_to_hsi_checker.sv
`timescale 1ns / 100ps

module rgb_to_hsi_checker
  import rgbhsi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  pixel_in_t  pixel_in,
  input  logic       done,
  input  pixel_out_t pixel_out,
  output int         fail_count,
  output int         pending
);

  pixel_out_t expected_pixels[$];

  localparam logic [31:0] ATAN_TBL [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  function automatic longint trunc_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  function automatic logic [31:0] vector_angle(longint x, longint y);
    logic [31:0] z;
    longint dx, dy;
    z = '0;
    if (y == 0) return (x > 0) ? 32'd0 : 32'h8000_0000;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 24; i++) begin
      dx = trunc_shift(y, i);
      dy = trunc_shift(x, i);
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += ATAN_TBL[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_TBL[i];
      end
    end
    return z;
  endfunction

  function automatic pixel_out_t convert_pixel(pixel_in_t p);
    pixel_out_t o;
    int unsigned r, g, b, total, lo;
    longint x, y;
    logic [63:0] prod;
    r = 32'(p.red);
    g = 32'(p.green);
    b = 32'(p.blue);
    total = r + g + b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    o = '0;
    if (total != 0 && total != 3 * lo) begin
      o.saturation_code = (lo == 0) ? 8'd255 : 8'((255 * (total - 3 * lo)) / total);
      x = (2 * longint'(r) - longint'(g) - longint'(b)) * 65536;
      y = (longint'(g) - longint'(b)) * 113512;
      prod = 64'(vector_angle(x, y)) * 64'd255;
      o.hue_code = prod[39:32];
    end
    o.intensity_code = 8'(total / 3);
    return o;
  endfunction

  assign pending = expected_pixels.size();

  always @(posedge clk) begin
    pixel_out_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (done) begin
        if (expected_pixels.size() == 0) begin
          $error("result beat with no pixel outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_out !== want) begin
            if (pixel_out.hue_code !== want.hue_code)
              $error("hue_code expected %0d actual %0d", want.hue_code, pixel_out.hue_code);
            if (pixel_out.saturation_code !== want.saturation_code)
              $error("saturation_code expected %0d actual %0d",
                     want.saturation_code, pixel_out.saturation_code);
            if (pixel_out.intensity_code !== want.intensity_code)
              $error("intensity_code expected %0d actual %0d",
                     want.intensity_code, pixel_out.intensity_code);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) expected_pixels.push_back(convert_pixel(pixel_in));
    end
  end

endmodule

>>> dv/tb_rgb_to_hsi_pixel.sv
`timescale 1ns / 100ps

module tb_rgb_to_hsi_pixel
  import rgbhsi_pkg::*;
();

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  pixel_in_t  pixel_in;
  logic       done;
  pixel_out_t pixel_out;
  int         fail_count;
  int         pending;
  int         idle_cycles;
  int         pixels_sent;

  rgb_to_hsi_pixel u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_in(pixel_in), .done(done), .pixel_out(pixel_out)
  );

  rgb_to_hsi_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel_in(pixel_in),
    .done(done), .pixel_out(pixel_out), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    start <= 1'b1;
    pixel_in <= '{red: r, green: g, blue: b};
    @(posedge clk);
    while (busy) @(posedge clk);
    pixels_sent++;
    gap = ($urandom_range(0, 3) == 0) ?
          (($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3)) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [7:0] r, g, b, lvl;
    idle_cycles = 0;
    pixels_sent = 0;
    rst <= 1'b1;
    start <= 1'b0;
    pixel_in <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(128, 128, 128);
    send_pixel(1, 1, 1);
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(255, 255, 0);
    send_pixel(0, 255, 255);
    send_pixel(255, 0, 255);
    send_pixel(200, 50, 50);
    send_pixel(20, 90, 90);
    send_pixel(1, 0, 0);
    send_pixel(0, 0, 1);
    send_pixel(255, 254, 254);
    send_pixel(254, 255, 255);
    send_pixel(10, 200, 201);
    send_pixel(10, 201, 200);
    send_pixel(255, 1, 0);
    send_pixel(170, 85, 255);

    for (int n = 0; n < 1800; n++) begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      case ($urandom_range(0, 9))
        0: begin lvl = 8'($urandom); r = lvl; g = lvl; b = lvl; end
        1: g = b;
        2: case ($urandom_range(0, 2)) 0: r = 0; 1: g = 0; default: b = 0; endcase
        3: begin
          r = 8'($urandom_range(0, 3));
          g = 8'($urandom_range(0, 3));
          b = 8'($urandom_range(0, 3));
        end
        4: begin g = 8'(r + $urandom_range(0, 2)); b = 8'(r + $urandom_range(0, 2)); end
        default: ;
      endcase
      send_pixel(r, g, b);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("%0d pixels converted: black, grey, primaries, zero minimum and green-equals-blue",
             pixels_sent);
    $display("cases included, with random start gaps.");
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
